/* hw/rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersection block
// Formats, hit codes, register indexes and the root cell payload.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int COORD_W = 32;
	localparam int OC_W    = 33;          // center minus origin
	localparam int SQ_W    = 66;          // oc * oc
	localparam int CR_W    = 65;          // oc * dir
	localparam int LEN_W   = 67;          // |oc|^2, unsigned
	localparam int TCA_W   = 67;          // oc . dir, signed
	localparam int MAG_W   = 65;          // |tca|
	localparam int LO_W    = 33;          // low split of |tca|
	localparam int HI_W    = MAG_W - LO_W;
	localparam int DIFF_W  = 68;          // rr - len2, signed
	localparam int TSQ_W   = 130;         // tca^2
	localparam int HS_W    = 136;         // signed half-chord square
	localparam int H_W     = 134;         // radicand bits handed to the cells
	localparam int ROOT_W  = H_W / 2;     // one root bit per cell
	localparam int REM_W   = ROOT_W + 2;
	localparam int T_W     = TCA_W + 2;
	localparam int CFG_AW  = 2;

	localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_AW-1:0] REG_CENTER_Z = 2'd2;
	localparam logic [CFG_AW-1:0] REG_RADIUS_SQ = 2'd3;

	typedef enum logic [1:0] {
		HIT_NONE    = 2'd0,
		HIT_OUTSIDE = 2'd1,
		HIT_INSIDE  = 2'd2
	} hit_kind_t;

	// Payload handed from cell to cell
	typedef struct packed {
		logic              miss;
		logic              outside;
		logic [TCA_W-1:0]  tca;
		logic [H_W-1:0]    h;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} rsi_cell_t;

endpackage

/* hw/rtl/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front: geometry front end
// Forms OC, |OC|^2, Tca, the outside test and the squared half chord.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] origin [3],
	input  logic signed [COORD_W-1:0] dir [3],
	input  logic signed [COORD_W-1:0] center [3],
	input  logic        [COORD_W-1:0] radius_squared,
	output logic                      out_valid,
	output rsi_cell_t                 out_cell
);

	logic               [5:0] vld_q;
	logic signed [OC_W-1:0]    oc_s1 [3];
	logic signed [COORD_W-1:0] d_s1 [3];
	logic signed [SQ_W-1:0]    sq_s2 [3];
	logic signed [CR_W-1:0]    cr_s2 [3];
	logic [LEN_W-1:0]          len2_s3;
	logic [TCA_W-1:0]          tca_s3;
	logic [TCA_W-1:0]          tca_s4, tca_s5, tca_s6;
	logic [DIFF_W-1:0]         diff_s4, diff_s5;
	logic [HI_W-1:0]           ah_s4;
	logic [LO_W-1:0]           al_s4;
	logic                      out_s4, out_s5, out_s6;
	logic                      miss_s4, miss_s5, miss_s6;
	logic [2*HI_W-1:0]         phh_s5;
	logic [HI_W+LO_W-1:0]      phl_s5;
	logic [2*LO_W-1:0]         pll_s5;
	logic [HS_W-1:0]           hs_s6;
	logic [MAG_W-1:0]          mag;
	logic [TSQ_W-1:0]          tsq;
	logic [47:0]               rr;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	assign rr  = {radius_squared, 16'b0};
	assign mag = tca_s3[TCA_W-1] ? MAG_W'(-tca_s3) : MAG_W'(tca_s3);
	assign tsq = {phh_s5, 66'b0} + {31'b0, phl_s5, 34'b0} + {64'b0, pll_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offsets from origin to center
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= {center[i][COORD_W-1], center[i]} - {origin[i][COORD_W-1], origin[i]};
				d_s1[i]  <= dir[i];
			end
			// s2: per-axis products
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= oc_s1[i] * oc_s1[i];
				cr_s2[i] <= oc_s1[i] * d_s1[i];
			end
			// s3: sum the axes
			len2_s3 <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]} + {1'b0, sq_s2[2]};
			tca_s3  <= {{2{cr_s2[0][CR_W-1]}}, cr_s2[0]} + {{2{cr_s2[1][CR_W-1]}}, cr_s2[1]}
				+ {{2{cr_s2[2][CR_W-1]}}, cr_s2[2]};
			// s4: outside test, early miss, split |tca|
			out_s4  <= len2_s3 >= {19'b0, rr};
			miss_s4 <= tca_s3[TCA_W-1] && (len2_s3 >= {19'b0, rr});
			diff_s4 <= {20'b0, rr} - {1'b0, len2_s3};
			tca_s4  <= tca_s3;
			ah_s4   <= mag[MAG_W-1:LO_W];
			al_s4   <= mag[LO_W-1:0];
			// s5: partial products of tca^2
			phh_s5  <= ah_s4 * ah_s4;
			phl_s5  <= ah_s4 * al_s4;
			pll_s5  <= al_s4 * al_s4;
			diff_s5 <= diff_s4;
			tca_s5  <= tca_s4;
			out_s5  <= out_s4;
			miss_s5 <= miss_s4;
			// s6: squared half chord
			hs_s6   <= {{36{diff_s5[DIFF_W-1]}}, diff_s5, 32'b0} + {6'b0, tsq};
			tca_s6  <= tca_s5;
			out_s6  <= out_s5;
			miss_s6 <= miss_s5;
		end
	end

	assign out_valid        = vld_q[5];
	assign out_cell.miss    = miss_s6 | hs_s6[HS_W-1];
	assign out_cell.outside = out_s6;
	assign out_cell.tca     = tca_s6;
	assign out_cell.h       = hs_s6[H_W-1:0];
	assign out_cell.rem     = '0;
	assign out_cell.root    = '0;

endmodule

/* hw/rtl/rsi_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one digit of the square root chain
// Takes two radicand bits, decides one root bit, hands the rest onward.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  rsi_cell_t in_cell,
	output logic      out_valid,
	output rsi_cell_t out_cell
);

	logic [REM_W+1:0] cand;
	logic [REM_W+1:0] trial;
	logic             take;
	logic             valid_q;
	rsi_cell_t        cell_s1;

	// Trial subtract for the next root bit
	assign cand  = {in_cell.rem, in_cell.h[H_W-1 -: 2]};
	assign trial = {2'b00, in_cell.root, 2'b01};
	assign take  = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1.miss    <= in_cell.miss;
			cell_s1.outside <= in_cell.outside;
			cell_s1.tca     <= in_cell.tca;
			cell_s1.h       <= {in_cell.h[H_W-3:0], 2'b00};
			cell_s1.rem     <= take ? REM_W'(cand - trial) : REM_W'(cand);
			cell_s1.root    <= {in_cell.root[ROOT_W-2:0], take};
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_s1;

endmodule

/* hw/rtl/ray_sphere_intersection.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersection: streaming ray against sphere test
// Closest-approach method in exact fixed point, one ray per clock when not stalled.
// ----------------------------------------------------------------------------
// One ray beat is taken every clock unless the output stalls; each result passes
// six front-end stages (offsets, products, sums, outside test, tca^2 partial
// products, half chord), a chain of 67 square root cells that each settle one
// root bit, and the output register that adds or subtracts the root, rounds and
// saturates. The whole pipe stalls together when the output beat is not taken.
// The user must write sphere registers only while no ray is in flight (not enforced).
module ray_sphere_intersection import rsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
	input  logic [191:0]       s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// distance (32 bits)
	output logic [31:0]        m_tdata,
	// hit_kind (2 bits)
	output logic [1:0]         m_tuser
);

	logic signed [COORD_W-1:0] center_q [3];
	logic [COORD_W-1:0]        radius_sq_q;
	logic signed [COORD_W-1:0] origin [3];
	logic signed [COORD_W-1:0] dir [3];
	logic                      en;
	logic                      chain_vld [ROOT_W+1];
	rsi_cell_t                 chain [ROOT_W+1];
	rsi_cell_t                 last;
	logic [T_W-1:0]            t_raw;
	logic [T_W-1:0]            t_rnd;
	logic [T_W-17:0]           t_sh;
	logic [31:0]               t_sat;
	logic                      fits;
	logic                      m_tvalid_q;
	logic [31:0]               dist_q;
	logic [1:0]                kind_q;

	// Hold the sphere registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			radius_sq_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CENTER_X:  center_q[0] <= cfg_wdata;
				REG_CENTER_Y:  center_q[1] <= cfg_wdata;
				REG_CENTER_Z:  center_q[2] <= cfg_wdata;
				REG_RADIUS_SQ: radius_sq_q <= cfg_wdata;
				default:       radius_sq_q <= radius_sq_q;
			endcase
		end
	end

	// Advance whenever the output slot is free or being drained
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			origin[i] = s_tdata[32*i +: 32];
			dir[i]    = s_tdata[96 + 32*i +: 32];
		end
	end

	rsi_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_tvalid),
		.origin         (origin),
		.dir            (dir),
		.center         (center_q),
		.radius_squared (radius_sq_q),
		.out_valid      (chain_vld[0]),
		.out_cell       (chain[0])
	);

	for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
		rsi_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_vld[k]),
			.in_cell   (chain[k]),
			.out_valid (chain_vld[k+1]),
			.out_cell  (chain[k+1])
		);
	end

	// Finish t: add or subtract the root, round half up, saturate
	assign last  = chain[ROOT_W];
	assign t_raw = last.outside
		? {{2{last.tca[TCA_W-1]}}, last.tca} - {2'b0, last.root}
		: {{2{last.tca[TCA_W-1]}}, last.tca} + {2'b0, last.root};
	assign t_rnd = t_raw + T_W'(32768);
	assign t_sh  = t_rnd[T_W-1:16];
	assign fits  = (t_sh[T_W-17:31] == '0) || (t_sh[T_W-17:31] == '1);
	assign t_sat = fits ? t_sh[31:0] : (t_sh[T_W-17] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= chain_vld[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.miss) begin
				kind_q <= HIT_NONE;
				dist_q <= '0;
			end else begin
				kind_q <= last.outside ? HIT_OUTSIDE : HIT_INSIDE;
				dist_q <= t_sat;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = dist_q;
	assign m_tuser  = kind_q;

endmodule

/* hw/rtl/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for ray_sphere_intersection
// Watches the stream ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Only the three hit kinds leave the block
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == HIT_NONE) || (m_tuser == HIT_OUTSIDE)
			|| (m_tuser == HIT_INSIDE))
		else $error("undefined hit kind");

	// A miss carries zero distance
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == HIT_NONE) |-> m_tdata == 32'd0)
		else $error("miss with nonzero distance");

	// Input side moves exactly when the output slot frees
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
